// ===== sv/rtt_timeout_estimator_assert.svh =====
// assertion macros for the rtt timeout estimator
// used by rte_core, no other dependencies
`ifndef RTT_TIMEOUT_ESTIMATOR_ASSERT_SVH
`define RTT_TIMEOUT_ESTIMATOR_ASSERT_SVH

// same-cycle implication
`define RTE_ASSERT_IMP(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RTE_ASSERT_NXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/rte_pkg.sv =====
// shared types and constants of the rtt timeout estimator
// no dependencies
package rte_pkg;

	localparam int MUL_A_W = 40;
	localparam int MUL_B_W = 20;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [MUL_B_W-1:0] US_PER_SEC = 20'd1000000;
	// floor(2^39 / 1e6), quotient is exact or one low for 32-bit values
	localparam logic [MUL_B_W-1:0] DIV_MAGIC  = 20'd549755;
	localparam int                 DIV_SHIFT  = 39;
	localparam logic [39:0]        MAX40      = 40'hFF_FFFF_FFFF;
	localparam logic [31:0]        MAX32      = 32'hFFFF_FFFF;
	localparam logic [16:0]        WEIGHT_ONE = 17'h1_0000;
	localparam logic [15:0]        ROUND_HALF = 16'h8000;
	localparam logic [29:0]        MAX_NSEC   = 30'd999999000;

	typedef enum logic {
		OP_MEASURE = 1'b0,
		OP_ARM     = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		REG_AVG_WEIGHT  = 2'd0,
		REG_DEV_WEIGHT  = 2'd1,
		REG_BASE_SEC    = 2'd2,
		REG_MIN_TIMEOUT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] avg_weight;
		logic [15:0] dev_weight;
		logic [15:0] base_timeout_sec;
		logic [31:0] minimum_timeout_us;
	} cfg_t;

	typedef struct packed {
		logic        opcode;
		logic [31:0] start_sec;
		logic [19:0] start_usec;
		logic [31:0] end_sec;
		logic [19:0] end_usec;
		logic        first_arm;
	} in_item_t;

	typedef struct packed {
		logic [15:0] timer_sec;
		logic [29:0] timer_nsec;
		logic        floor_applied;
		logic [31:0] smoothed_rtt_us;
		logic [31:0] deviation_us;
	} res_t;

endpackage

// ===== sv/rte_cfg.sv =====
// configuration register bank of the rtt timeout estimator
// depends on rte_pkg
module rte_cfg import rte_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.avg_weight         <= 16'd8192;
			cfg_q.dev_weight         <= 16'd16384;
			cfg_q.base_timeout_sec   <= 16'd3;
			cfg_q.minimum_timeout_us <= 32'd1000000;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_AVG_WEIGHT:  cfg_q.avg_weight         <= cfg_data[15:0];
				REG_DEV_WEIGHT:  cfg_q.dev_weight         <= cfg_data[15:0];
				REG_BASE_SEC:    cfg_q.base_timeout_sec   <= cfg_data[15:0];
				REG_MIN_TIMEOUT: cfg_q.minimum_timeout_us <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== sv/rte_mul.sv =====
// shared 40x20 unsigned multiplier with registered product
// depends on rte_pkg
module rte_mul import rte_pkg::*; (
	input  logic               clk,
	input  logic [MUL_A_W-1:0] mul_a,
	input  logic [MUL_B_W-1:0] mul_b,
	output logic [MUL_P_W-1:0] prod
);

	logic [MUL_P_W-1:0] prod_q;

	assign prod = prod_q;

	always_ff @(posedge clk) begin
		prod_q <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
	end

endmodule

// ===== sv/rte_core.sv =====
// sequencer and datapath: sample, smoothed rtt, deviation, interval and split
// depends on rte_pkg, rte_mul and rtt_timeout_estimator_assert.svh
`include "rtt_timeout_estimator_assert.svh"

module rte_core import rte_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	output logic     res_valid,
	input  logic     res_ready,
	output res_t     res
);

	localparam int XW = 32 + FRAC_BITS;

	typedef enum logic [3:0] {
		S_IDLE, S_SMUL, S_SAMP, S_A1, S_A2, S_ASUM, S_DIFF, S_D2, S_DSUM,
		S_IVL, S_Q1, S_Q2, S_Q3, S_DONE
	} state_t;

	state_t             state_q;
	in_item_t           item_q;
	logic [60:0]        acc_q;
	logic [39:0]        x_q;
	logic [39:0]        diff_q;
	logic [39:0]        srtt_q;
	logic [39:0]        dev_q;
	logic [31:0]        interval_q;
	logic [12:0]        quot_q;
	logic [15:0]        res_sec_q;
	logic [29:0]        res_nsec_q;
	logic               res_floor_q;

	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [MUL_P_W-1:0] prod;

	logic [32:0]        sec_diff;
	logic               sec_neg;
	logic [31:0]        sec_mag;
	logic signed [20:0] usec_diff;
	logic signed [53:0] prod_mag;
	logic signed [53:0] sample;
	logic [31:0]        sample_us;
	logic [XW-1:0]      x_wide;
	logic [39:0]        x_next;
	logic [16:0]        compl_avg;
	logic [16:0]        compl_dev;
	logic [60:0]        blend_sum;
	logic [44:0]        blend_sh;
	logic [39:0]        blend_sat;
	logic [42:0]        iv_sum;
	logic [42:0]        iv_shr;
	logic [12:0]        quot0;
	logic [20:0]        rem_raw;
	logic               rem_over;
	logic [19:0]        rem_fix;
	logic [12:0]        quot_fix;
	logic [29:0]        nsec_val;
	logic [39:0]        srtt_whole;
	logic [39:0]        dev_whole;

	rte_mul u_mul (
		.clk   (clk),
		.mul_a (mul_a),
		.mul_b (mul_b),
		.prod  (prod)
	);

	// timestamp difference
	assign sec_diff  = {1'b0, item_q.end_sec} - {1'b0, item_q.start_sec};
	assign sec_neg   = sec_diff[32];
	assign sec_mag   = sec_neg ? 32'(-sec_diff) : sec_diff[31:0];
	assign usec_diff = $signed({1'b0, item_q.end_usec}) - $signed({1'b0, item_q.start_usec});
	assign prod_mag  = $signed({2'b00, prod[51:0]});
	assign sample    = (sec_neg ? -prod_mag : prod_mag) + 54'(usec_diff);

	always_comb begin
		if (sample[53]) begin
			sample_us = 32'd0;
		end else if (|sample[52:32]) begin
			sample_us = MAX32;
		end else begin
			sample_us = sample[31:0];
		end
	end

	assign x_wide = XW'(sample_us) << FRAC_BITS;
	assign x_next = (64'(x_wide) > 64'(MAX40)) ? MAX40 : 40'(x_wide);

	// exponential average, round half up
	assign compl_avg = WEIGHT_ONE - {1'b0, cfg.avg_weight};
	assign compl_dev = WEIGHT_ONE - {1'b0, cfg.dev_weight};
	assign blend_sum = acc_q + 61'(prod);
	assign blend_sh  = blend_sum[60:16];
	assign blend_sat = (|blend_sh[44:40]) ? MAX40 : blend_sh[39:0];

	assign iv_sum = 43'(srtt_q) + {1'b0, dev_q, 2'b00};
	assign iv_shr = iv_sum >> FRAC_BITS;

	// split into seconds and remainder
	assign quot0    = prod[DIV_SHIFT+12:DIV_SHIFT];
	assign rem_raw  = 21'(interval_q - prod[31:0]);
	assign rem_over = rem_raw >= 21'(US_PER_SEC);
	assign rem_fix  = rem_over ? 20'(rem_raw - 21'(US_PER_SEC)) : rem_raw[19:0];
	assign quot_fix = rem_over ? quot_q + 13'd1 : quot_q;
	// times 1000 as 1024 - 16 - 8
	assign nsec_val = (30'(rem_fix) << 10) - (30'(rem_fix) << 4) - (30'(rem_fix) << 3);

	always_comb begin
		unique case (state_q)
			S_SMUL: begin
				mul_a = 40'(sec_mag);
				mul_b = US_PER_SEC;
			end
			S_A1: begin
				mul_a = srtt_q;
				mul_b = 20'(compl_avg);
			end
			S_A2: begin
				mul_a = x_q;
				mul_b = 20'(cfg.avg_weight);
			end
			S_DIFF: begin
				mul_a = dev_q;
				mul_b = 20'(compl_dev);
			end
			S_D2: begin
				mul_a = diff_q;
				mul_b = 20'(cfg.dev_weight);
			end
			S_Q1: begin
				mul_a = 40'(interval_q);
				mul_b = DIV_MAGIC;
			end
			S_Q2: begin
				mul_a = 40'(quot0);
				mul_b = US_PER_SEC;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			srtt_q     <= '0;
			dev_q      <= '0;
			interval_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_item;
						if (opcode_t'(in_item.opcode) == OP_MEASURE) begin
							res_floor_q <= 1'b0;
							state_q     <= S_SMUL;
						end else if (in_item.first_arm) begin
							res_sec_q   <= cfg.base_timeout_sec;
							res_nsec_q  <= '0;
							res_floor_q <= 1'b0;
							state_q     <= S_DONE;
						end else if (interval_q < cfg.minimum_timeout_us) begin
							res_sec_q   <= 16'd1;
							res_nsec_q  <= '0;
							res_floor_q <= 1'b1;
							state_q     <= S_DONE;
						end else begin
							res_floor_q <= 1'b0;
							state_q     <= S_Q1;
						end
					end
				end
				S_SMUL: state_q <= S_SAMP;
				S_SAMP: begin
					x_q     <= x_next;
					state_q <= S_A1;
				end
				S_A1: state_q <= S_A2;
				S_A2: begin
					acc_q   <= 61'(prod) + 61'(ROUND_HALF);
					state_q <= S_ASUM;
				end
				S_ASUM: begin
					srtt_q  <= blend_sat;
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					diff_q  <= (x_q >= srtt_q) ? x_q - srtt_q : srtt_q - x_q;
					state_q <= S_D2;
				end
				S_D2: begin
					acc_q   <= 61'(prod) + 61'(ROUND_HALF);
					state_q <= S_DSUM;
				end
				S_DSUM: begin
					dev_q   <= blend_sat;
					state_q <= S_IVL;
				end
				S_IVL: begin
					interval_q <= (|iv_shr[42:32]) ? MAX32 : iv_shr[31:0];
					state_q    <= S_Q1;
				end
				S_Q1: state_q <= S_Q2;
				S_Q2: begin
					quot_q  <= quot0;
					state_q <= S_Q3;
				end
				S_Q3: begin
					res_sec_q  <= 16'(quot_fix);
					res_nsec_q <= nsec_val;
					state_q    <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign srtt_whole = srtt_q >> FRAC_BITS;
	assign dev_whole  = dev_q >> FRAC_BITS;

	assign in_ready              = state_q == S_IDLE;
	assign res_valid             = state_q == S_DONE;
	assign res.timer_sec         = res_sec_q;
	assign res.timer_nsec        = res_nsec_q;
	assign res.floor_applied     = res_floor_q;
	assign res.smoothed_rtt_us   = (|srtt_whole[39:32]) ? MAX32 : srtt_whole[31:0];
	assign res.deviation_us      = (|dev_whole[39:32]) ? MAX32 : dev_whole[31:0];

	`RTE_ASSERT_IMP(a_measure_no_floor, clk, arst_n,
		res_valid && item_q.opcode == OP_MEASURE, !res.floor_applied, "floor on measure")
	`RTE_ASSERT_IMP(a_nsec_range, clk, arst_n,
		res_valid, res.timer_nsec <= MAX_NSEC, "nanoseconds out of range")
	`RTE_ASSERT_NXT(a_srtt_hold, clk, arst_n,
		state_q != S_ASUM, $stable(srtt_q), "smoothed rtt changed outside update")
	`RTE_ASSERT_NXT(a_dev_hold, clk, arst_n,
		state_q != S_DSUM, $stable(dev_q), "deviation changed outside update")
	`RTE_ASSERT_NXT(a_leave_idle, clk, arst_n,
		in_valid && in_ready, state_q != S_IDLE, "accepted word not started")

endmodule

// ===== sv/rtt_timeout_estimator.sv =====
// from input accept to result on m_axis: a measure runs the sample, average, deviation, interval
// and split states; an arm goes straight to done, or first splits the stored interval
// one word at a time: next word taken once the sequencer is back in idle,
// which it reaches only after its result is taken by the output word register
// arst_n clears state, config to defaults and the output valid flag; no clearing pass
module rtt_timeout_estimator import rte_pkg::*; #(
	parameter int FRAC_BITS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// start_sec, start_usec, end_sec, end_usec, first_arm, zero pad
	input  logic [111:0] s_axis_tdata,
	// opcode
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// timer_sec, timer_nsec, smoothed_rtt_us, deviation_us, zero pad
	output logic [111:0] m_axis_tdata,
	// floor_applied
	output logic         m_axis_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);

	cfg_t     cfg;
	in_item_t in_item;
	logic     res_valid;
	logic     res_ready;
	res_t     res;
	logic     out_valid_q;
	res_t     out_q;

	rte_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign in_item.opcode     = s_axis_tuser;
	assign in_item.start_sec  = s_axis_tdata[31:0];
	assign in_item.start_usec = s_axis_tdata[51:32];
	assign in_item.end_sec    = s_axis_tdata[83:52];
	assign in_item.end_usec   = s_axis_tdata[103:84];
	assign in_item.first_arm  = s_axis_tdata[104];

	rte_core #(
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_item   (in_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output word register
	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q.deviation_us, out_q.smoothed_rtt_us,
		out_q.timer_nsec, out_q.timer_sec};
	assign m_axis_tuser  = out_q.floor_applied;

endmodule
